/* src/psw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_pkg
// Shared types, codes and constants of the pending signal set with waiter.
// ----------------------------------------------------------------------------
package psw_pkg;

    localparam int MAX_SIGNALS = 64;
    localparam int SIG_W       = 6;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RECEPTION_ON = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WANTED_MASK  = 1'b1;

    // Item kinds.
    localparam logic KIND_POST    = 1'b0;
    localparam logic KIND_RECEIVE = 1'b1;

    // Receiver handshake codes; the unused code behaves as idle.
    localparam logic [1:0] HS_IDLE      = 2'd0;
    localparam logic [1:0] HS_HASWAITER = 2'd1;
    localparam logic [1:0] HS_HASSIGNAL = 2'd2;

    typedef logic [SIG_W-1:0]      t_sig;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the incoming transaction
        logic post;      // execute a post
        logic pre_move;  // move pending into snapshot after a wait
        logic scan;      // one step of the receive sequencer
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic kind;
        logic after_wait;
        logic scan_final; // the current scan step produces the result
    } t_status;

endpackage

/* src/psw_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_ctrl
// Controller: sequences capture, post execution, receive scan steps and the
// output handshake.
// ----------------------------------------------------------------------------
module psw_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  psw_pkg::t_status i_status,
    output psw_pkg::t_cmd   o_cmd
);
    import psw_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_PREP;
                end
            end
            ST_PREP: begin
                if (i_status.kind == KIND_POST) begin
                    o_cmd.post = 1'b1;
                    n_state    = ST_OUT;
                end else begin
                    o_cmd.pre_move = i_status.after_wait;
                    n_state        = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_final) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A receive refills the snapshot at most once, so a scan step that follows a scan step always gives the result.
    a_scan_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && $past(r_state) == ST_SCAN) |-> i_status.scan_final)
        else $error("receive scan exceeded two steps");

    a_scan_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> ($past(r_state) == ST_PREP || $past(r_state) == ST_SCAN))
        else $error("scan entered without a receive");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input taken while a result is pending");

endmodule

/* src/psw_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_datapath
// Datapath: configuration, pending and snapshot masks, handshake state,
// lowest-bit encoder and result registers.
// ----------------------------------------------------------------------------
module psw_datapath #(
    parameter int SIGNAL_COUNT = psw_pkg::MAX_SIGNALS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [psw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  psw_pkg::t_cfg_data         i_cfg_wdata,
    input  logic                       i_kind,
    input  psw_pkg::t_sig              i_signal_number,
    input  psw_pkg::t_cmd              i_cmd,
    output psw_pkg::t_status           o_status,
    output logic                       o_accepted,
    output logic                       o_wake_receiver,
    output logic                       o_got_signal,
    output psw_pkg::t_sig              o_signal_out,
    output logic                       o_waiter_armed,
    output logic                       o_order_error
);
    import psw_pkg::*;

    typedef logic [SIGNAL_COUNT-1:0] t_mask;

    logic               r_reception_on;
    t_mask              r_wanted;
    t_mask              r_pending, n_pending;
    t_mask              r_snap, n_snap;
    logic [1:0]         r_hs, n_hs;
    logic               r_after_wait, n_after_wait;
    logic               r_kind;
    t_sig               r_sig;

    logic               r_accepted, n_accepted;
    logic               r_wake, n_wake;
    logic               r_got, n_got;
    t_sig               r_sig_out, n_sig_out;
    logic               r_armed, n_armed;
    logic               r_err, n_err;

    logic [MAX_SIGNALS-1:0] w_bit64;
    t_mask              w_bit;
    logic               w_in_range;
    logic               w_post_ok;
    t_mask              w_low;
    t_sig               w_low_idx;
    logic               w_snap_nz;

    assign w_bit64    = MAX_SIGNALS'(1) << r_sig;
    assign w_bit      = w_bit64[SIGNAL_COUNT-1:0];
    assign w_in_range = ({1'b0, r_sig} < (SIG_W + 1)'(SIGNAL_COUNT));
    assign w_post_ok  = r_reception_on && w_in_range && ((r_wanted & w_bit) != '0);

    // Isolate the lowest set bit of the snapshot and encode its position.
    assign w_snap_nz = (r_snap != '0);
    assign w_low     = r_snap & (~r_snap + t_mask'(1));

    always_comb begin
        w_low_idx = '0;
        for (int i = 0; i < SIGNAL_COUNT; i++) begin
            if (w_low[i]) begin
                w_low_idx = w_low_idx | SIG_W'(i);
            end
        end
    end

    always_comb begin
        n_pending    = r_pending;
        n_snap       = r_snap;
        n_hs         = r_hs;
        n_after_wait = r_after_wait;
        n_accepted   = r_accepted;
        n_wake       = r_wake;
        n_got        = r_got;
        n_sig_out    = r_sig_out;
        n_armed      = r_armed;
        n_err        = r_err;
        o_status.kind       = r_kind;
        o_status.after_wait = r_after_wait;
        o_status.scan_final = 1'b1;

        if (i_cmd.load) begin
            n_accepted = 1'b0;
            n_wake     = 1'b0;
            n_got      = 1'b0;
            n_sig_out  = '0;
            n_armed    = 1'b0;
            n_err      = 1'b0;
        end

        if (i_cmd.post && w_post_ok) begin
            n_accepted = 1'b1;
            if ((r_pending & w_bit) == '0) begin
                n_pending = r_pending | w_bit;
                if (r_hs == HS_HASWAITER) begin
                    n_hs   = HS_IDLE;
                    n_wake = 1'b1;
                end else if (r_hs != HS_HASSIGNAL) begin
                    n_hs = HS_HASSIGNAL;
                end
            end
        end

        if (i_cmd.pre_move) begin
            n_after_wait = 1'b0;
            n_snap       = r_pending;
            n_pending    = '0;
        end

        if (i_cmd.scan) begin
            if (w_snap_nz) begin
                n_snap    = r_snap & (r_snap - t_mask'(1));
                n_got     = 1'b1;
                n_sig_out = w_low_idx;
            end else if (r_hs == HS_HASWAITER) begin
                n_err = 1'b1;
            end else if (r_hs == HS_HASSIGNAL) begin
                // Refill from the pending set and scan again.
                n_hs                = HS_IDLE;
                n_snap              = r_pending;
                n_pending           = '0;
                o_status.scan_final = 1'b0;
            end else begin
                n_hs         = HS_HASWAITER;
                n_after_wait = 1'b1;
                n_armed      = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reception_on <= 1'b0;
            r_wanted       <= '0;
            r_pending      <= '0;
            r_snap         <= '0;
            r_hs           <= HS_IDLE;
            r_after_wait   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_RECEPTION_ON: r_reception_on <= i_cfg_wdata[0];
                    CFG_WANTED_MASK:  r_wanted       <= i_cfg_wdata[SIGNAL_COUNT-1:0];
                    default: ;
                endcase
            end
            r_pending    <= n_pending;
            r_snap       <= n_snap;
            r_hs         <= n_hs;
            r_after_wait <= n_after_wait;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_sig  <= i_signal_number;
        end
        r_accepted <= n_accepted;
        r_wake     <= n_wake;
        r_got      <= n_got;
        r_sig_out  <= n_sig_out;
        r_armed    <= n_armed;
        r_err      <= n_err;
    end

    assign o_accepted      = r_accepted;
    assign o_wake_receiver = r_wake;
    assign o_got_signal    = r_got;
    assign o_signal_out    = r_sig_out;
    assign o_waiter_armed  = r_armed;
    assign o_order_error   = r_err;

endmodule

/* src/pending_signal_set_with_waiter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pending_signal_set_with_waiter
// Pending signal collector with a single receiver handshake.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A post goes idle, prepare, output; a
// receive adds a scan step, and a further one when an empty snapshot must be
// refilled from the pending set by the receive sequencer. The next transaction
// is taken in the cycle after the result is delivered. Configuration writes
// take effect at once; the user must make them while idle (not enforced).
module pending_signal_set_with_waiter #(
    parameter int SIGNAL_COUNT = psw_pkg::MAX_SIGNALS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [psw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  psw_pkg::t_cfg_data            i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_kind,
    input  psw_pkg::t_sig                 i_signal_number,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_accepted,
    output logic                          o_wake_receiver,
    output logic                          o_got_signal,
    output psw_pkg::t_sig                 o_signal_out,
    output logic                          o_waiter_armed,
    output logic                          o_order_error
);
    import psw_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    psw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    psw_datapath #(
        .SIGNAL_COUNT (SIGNAL_COUNT)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_kind          (i_kind),
        .i_signal_number (i_signal_number),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_accepted      (o_accepted),
        .o_wake_receiver (o_wake_receiver),
        .o_got_signal    (o_got_signal),
        .o_signal_out    (o_signal_out),
        .o_waiter_armed  (o_waiter_armed),
        .o_order_error   (o_order_error)
    );

endmodule

/* sim/psw_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_result_checker
// Watches the configuration port and both channels of the pending signal
// set. Every accepted transaction is run through a local model of the pending
// set, the snapshot and the receiver handshake. Every delivered result is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module psw_result_checker #(
    parameter int SIGNAL_COUNT = psw_pkg::MAX_SIGNALS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [psw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  psw_pkg::t_cfg_data            i_cfg_wdata,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic                          i_kind,
    input  psw_pkg::t_sig                 i_signal_number,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic                          i_accepted,
    input  logic                          i_wake_receiver,
    input  logic                          i_got_signal,
    input  psw_pkg::t_sig                 i_signal_out,
    input  logic                          i_waiter_armed,
    input  logic                          i_order_error,
    output int                            o_fail_count,
    output int                            o_outstanding
);
    import psw_pkg::*;

    typedef struct packed {
        logic accepted;
        logic wake_receiver;
        logic got_signal;
        t_sig signal_out;
        logic waiter_armed;
        logic order_error;
    } t_signal_result;

    localparam logic [63:0] VALID_SIGNALS =
        (SIGNAL_COUNT >= 64) ? '1 : ((64'd1 << SIGNAL_COUNT) - 64'd1);

    // Local copy of the configuration and of the block's state.
    logic        rx_enabled;
    logic [63:0] wanted_signals;
    logic [63:0] pending_set;
    logic [63:0] snapshot_set;
    logic [1:0]  handshake;
    logic        refill_after_wait;

    t_signal_result expected_results[$];
    int             mismatch_count;

    assign o_fail_count = mismatch_count;

    function automatic void refill_snapshot();
        snapshot_set = pending_set & VALID_SIGNALS;
        pending_set  = '0;
    endfunction

    function automatic t_signal_result deliver_signal(logic kind, t_sig number);
        t_signal_result r;
        logic [63:0]    sig_bit;
        int             pass;
        int             i;
        r = '0;
        if (kind == KIND_POST) begin
            sig_bit = 64'd1 << number;
            if (!rx_enabled || int'(number) >= SIGNAL_COUNT || (wanted_signals & sig_bit) == 0)
                return r;
            r.accepted = 1'b1;
            if ((pending_set & sig_bit) != 0)
                return r;
            pending_set |= sig_bit;
            if (handshake == HS_HASWAITER) begin
                handshake       = HS_IDLE;
                r.wake_receiver = 1'b1;
            end else if (handshake != HS_HASSIGNAL) begin
                handshake = HS_HASSIGNAL;
            end
            return r;
        end

        if (refill_after_wait) begin
            refill_after_wait = 1'b0;
            refill_snapshot();
        end
        // A held signal may require one refill before the scan finds work.
        for (pass = 0; pass < 3; pass++) begin
            snapshot_set &= VALID_SIGNALS;
            for (i = 0; i < 64; i++) begin
                if (snapshot_set[i]) begin
                    snapshot_set[i] = 1'b0;
                    r.got_signal    = 1'b1;
                    r.signal_out    = t_sig'(i);
                    return r;
                end
            end
            if (handshake == HS_HASWAITER) begin
                r.order_error = 1'b1;
                return r;
            end
            if (handshake == HS_HASSIGNAL) begin
                handshake = HS_IDLE;
                refill_snapshot();
                continue;
            end
            handshake         = HS_HASWAITER;
            refill_after_wait = 1'b1;
            r.waiter_armed    = 1'b1;
            return r;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_signal_result want;
        if (!i_rst_n) begin
            rx_enabled        = 1'b0;
            wanted_signals    = '0;
            pending_set       = '0;
            snapshot_set      = '0;
            handshake         = HS_IDLE;
            refill_after_wait = 1'b0;
            mismatch_count    = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_RECEPTION_ON: rx_enabled = i_cfg_wdata[0];
                    CFG_WANTED_MASK:  wanted_signals = i_cfg_wdata;
                    default: ;
                endcase
            end

            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result delivered with no transaction outstanding");
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_accepted !== want.accepted) begin
                        $error("accepted: expected %0d, got %0d", want.accepted, i_accepted);
                        mismatch_count++;
                    end
                    if (i_wake_receiver !== want.wake_receiver) begin
                        $error("wake_receiver: expected %0d, got %0d",
                               want.wake_receiver, i_wake_receiver);
                        mismatch_count++;
                    end
                    if (i_got_signal !== want.got_signal) begin
                        $error("got_signal: expected %0d, got %0d",
                               want.got_signal, i_got_signal);
                        mismatch_count++;
                    end
                    if (i_signal_out !== want.signal_out) begin
                        $error("signal_out: expected %0d, got %0d",
                               want.signal_out, i_signal_out);
                        mismatch_count++;
                    end
                    if (i_waiter_armed !== want.waiter_armed) begin
                        $error("waiter_armed: expected %0d, got %0d",
                               want.waiter_armed, i_waiter_armed);
                        mismatch_count++;
                    end
                    if (i_order_error !== want.order_error) begin
                        $error("order_error: expected %0d, got %0d",
                               want.order_error, i_order_error);
                        mismatch_count++;
                    end
                end
            end

            if (i_in_valid && i_in_ready)
                expected_results.push_back(deliver_signal(i_kind, i_signal_number));
        end
        o_outstanding = expected_results.size();
    end

endmodule

/* sim/pending_signal_set_with_waiter_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pending_signal_set_with_waiter_test
// Drives posts and receives into the pending signal set under several
// reception and wanted-mask settings, with random stalls on both channels.
// A directed sequence walks the receiver handshake through arming, waking,
// repeated posts, refills and the armed-receive error; random phases follow.
// ----------------------------------------------------------------------------
module pending_signal_set_with_waiter_test;
    import psw_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    t_cfg_data            i_cfg_wdata;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_kind;
    t_sig                 i_signal_number;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_accepted;
    logic                 o_wake_receiver;
    logic                 o_got_signal;
    t_sig                 o_signal_out;
    logic                 o_waiter_armed;
    logic                 o_order_error;

    int   fail_count;
    int   outstanding;
    logic no_gaps;

    pending_signal_set_with_waiter u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_signal_number (i_signal_number),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_accepted      (o_accepted),
        .o_wake_receiver (o_wake_receiver),
        .o_got_signal    (o_got_signal),
        .o_signal_out    (o_signal_out),
        .o_waiter_armed  (o_waiter_armed),
        .o_order_error   (o_order_error)
    );

    psw_result_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_signal_number (i_signal_number),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_accepted      (o_accepted),
        .i_wake_receiver (o_wake_receiver),
        .i_got_signal    (o_got_signal),
        .i_signal_out    (o_signal_out),
        .i_waiter_armed  (o_waiter_armed),
        .i_order_error   (o_order_error),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

    // Result side: stall a random number of cycles before each transaction.
    initial begin
        int stall;
        i_out_ready = 1'b0;
        while (i_rst_n !== 1'b1)
            @(negedge i_clk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 8);
            if (stall != 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // Holds the write enable high across exactly one rising edge.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] index, t_cfg_data data);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = index;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    // Called at a falling edge; leaves valid high so that a back-to-back
    // transaction keeps it high without a glitch.
    task automatic send_item(logic kind, t_sig number);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      = 1'b1;
        i_kind          = kind;
        i_signal_number = number;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Lets every outstanding result drain so the block is idle.
    task automatic drain();
        i_in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge i_clk);
    endtask

    task automatic set_config(logic rx_on, t_cfg_data mask);
        cfg_write(CFG_RECEPTION_ON, t_cfg_data'(rx_on));
        cfg_write(CFG_WANTED_MASK, mask);
    endtask

    task automatic random_phase(logic rx_on, t_cfg_data mask, int count);
        t_sig number;
        int   tries;
        set_config(rx_on, mask);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 31) == 0)
                no_gaps = ~no_gaps;
            if ($urandom_range(0, 9) < 4) begin
                send_item(KIND_RECEIVE, t_sig'($urandom));
            end else begin
                // Mostly wanted signals, often from a small range so repeats occur.
                number = ($urandom_range(0, 2) == 0) ? t_sig'($urandom_range(0, 7))
                                                     : t_sig'($urandom);
                tries = 0;
                if ($urandom_range(0, 3) != 0 && mask != 0) begin
                    while (!mask[number] && tries < 500) begin
                        number = t_sig'($urandom);
                        tries++;
                    end
                end
                send_item(KIND_POST, number);
            end
        end
        no_gaps = 1'b0;
        drain();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_index     = CFG_RECEPTION_ON;
        i_cfg_wdata     = '0;
        i_in_valid      = 1'b0;
        i_kind          = KIND_POST;
        i_signal_number = '0;
        no_gaps         = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Handshake walk: arm, armed receive, wake, refill after the wait,
        // repeated post, held signal refilled once the snapshot runs dry.
        set_config(1'b1, '1);
        send_item(KIND_RECEIVE, '0);
        send_item(KIND_RECEIVE, '1);
        send_item(KIND_POST, 6'd0);
        send_item(KIND_RECEIVE, '0);
        send_item(KIND_RECEIVE, '0);
        send_item(KIND_POST, 6'd63);
        send_item(KIND_POST, 6'd63);
        send_item(KIND_POST, 6'd5);
        send_item(KIND_RECEIVE, '0);
        send_item(KIND_RECEIVE, '0);
        send_item(KIND_RECEIVE, '0);
        send_item(KIND_POST, 6'd10);
        send_item(KIND_POST, 6'd20);
        send_item(KIND_RECEIVE, '0);
        send_item(KIND_POST, 6'd30);
        send_item(KIND_RECEIVE, '0);
        send_item(KIND_RECEIVE, '0);
        drain();

        // Reception off refuses every post.
        set_config(1'b0, '1);
        send_item(KIND_POST, 6'd7);
        send_item(KIND_RECEIVE, '0);
        drain();

        // Unwanted signals are refused.
        set_config(1'b1, 64'h5555_5555_5555_5555);
        send_item(KIND_POST, 6'd1);
        send_item(KIND_POST, 6'd2);
        send_item(KIND_POST, 6'd62);
        send_item(KIND_RECEIVE, '0);
        drain();

        random_phase(1'b1, '1, 140);
        random_phase(1'b1, {$urandom, $urandom}, 140);
        random_phase(1'b1, 64'h8000_0000_0000_0001, 140);
        random_phase(1'b0, {$urandom, $urandom}, 140);
        random_phase(1'b1, '0, 140);
        random_phase(1'b1, {$urandom, $urandom} & {$urandom, $urandom}, 140);

        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* sim.f */
src/psw_pkg.sv
src/psw_ctrl.sv
src/psw_datapath.sv
src/pending_signal_set_with_waiter.sv
sim/psw_result_checker.sv
sim/pending_signal_set_with_waiter_test.sv
